// ===== sv/oas_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and base matching for the overlap alignment score fill
// no dependencies

package oas_pkg;

  localparam int SCORE_W = 20;
  localparam int SUM_W   = SCORE_W + 1;
  localparam int PEN_W   = 7;
  localparam int BASE_W  = 8;
  localparam int COL_W   = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [PEN_W-1:0] MATCH_RST      = 7'sd5;
  localparam logic signed [PEN_W-1:0] MISMATCH_RST   = -7'sd4;
  localparam logic signed [PEN_W-1:0] GAP_OPEN_RST   = -7'sd12;
  localparam logic signed [PEN_W-1:0] GAP_EXTEND_RST = -7'sd4;

  localparam logic [BASE_W-1:0] CHAR_N    = "N";
  localparam logic [BASE_W-1:0] CHAR_N_LC = "n";

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH      = 2'd0,
    CFG_MISMATCH   = 2'd1,
    CFG_GAP_OPEN   = 2'd2,
    CFG_GAP_EXTEND = 2'd3
  } oas_cfg_idx_t;

  typedef enum logic [1:0] {
    MV_DIAG = 2'd0,
    MV_UP   = 2'd1,
    MV_LEFT = 2'd2
  } oas_move_t;

  typedef struct packed {
    logic signed [PEN_W-1:0] match;
    logic signed [PEN_W-1:0] mismatch;
    logic signed [PEN_W-1:0] gap_start;
    logic signed [PEN_W-1:0] gap_cont;
  } oas_scores_t;

  // per-cell load control for sequence a
  typedef struct packed {
    logic              wr;
    logic              clear;
    logic [BASE_W-1:0] base;
  } oas_load_t;

  // one column word travelling down the row of cells
  typedef struct packed {
    logic                      vld;
    logic [BASE_W-1:0]         b;
    logic                      first;
    logic                      diag_ok;
    logic signed [SCORE_W-1:0] diag_src;
    logic                      up_ok;
    logic signed [SCORE_W-1:0] up_src;
    oas_move_t                 up_mv;
    logic [COL_W-1:0]          col;
  } oas_token_t;

  function automatic logic [BASE_W-1:0] upcase(logic [BASE_W-1:0] c);
    logic [BASE_W-1:0] r;
    r = c;
    if (c >= "a" && c <= "z") r = c - 8'd32;
    return r;
  endfunction

  function automatic logic [3:0] iupac_set(logic [BASE_W-1:0] c);
    logic [3:0] s;
    unique case (upcase(c))
      "A":     s = 4'd1;
      "C":     s = 4'd2;
      "G":     s = 4'd4;
      "T":     s = 4'd8;
      "R":     s = 4'd5;
      "Y":     s = 4'd10;
      "S":     s = 4'd6;
      "W":     s = 4'd9;
      "K":     s = 4'd12;
      "M":     s = 4'd3;
      "B":     s = 4'd14;
      "D":     s = 4'd13;
      "H":     s = 4'd11;
      "V":     s = 4'd7;
      "N":     s = 4'd15;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic bases_match(logic [BASE_W-1:0] a, logic [BASE_W-1:0] b);
    logic [3:0] ma;
    logic [3:0] mb;
    logic [3:0] both;
    logic       m;
    ma   = iupac_set(a);
    mb   = iupac_set(b);
    both = ma & mb;
    m = (upcase(a) == upcase(b))
        || (a == CHAR_N) || (a == CHAR_N_LC) || (b == CHAR_N) || (b == CHAR_N_LC)
        || ((ma != 4'd0) && (mb != 4'd0) && ((both == ma) || (both == mb)));
    return m;
  endfunction

endpackage

// ===== sv/oas_item_if.sv =====
`timescale 1ns / 1ps
// input channel: one word is an a-load or a b column base
// depends on oas_pkg

interface oas_item_if import oas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BASE_W-1:0] base;
  logic              restart;

  modport source (output valid, output op, output base, output restart, input ready);
  modport sink   (input valid, input op, input base, input restart, output ready);
endinterface

// ===== sv/oas_result_if.sv =====
`timescale 1ns / 1ps
// output channel: one word per b column
// depends on oas_pkg

interface oas_result_if import oas_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COL_W-1:0]          column_index;
  logic signed [SCORE_W-1:0] last_row_score;
  logic [1:0]                last_row_move;
  logic                      last_row_valid;

  modport source (output valid, output column_index, output last_row_score,
                  output last_row_move, output last_row_valid, input ready);
  modport sink   (input valid, input column_index, input last_row_score,
                  input last_row_move, input last_row_valid, output ready);
endinterface

// ===== sv/oas_cfg_if.sv =====
`timescale 1ns / 1ps
// configuration write channel: register index and data
// depends on oas_pkg

interface oas_cfg_if import oas_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/oas_cell.sv =====
`timescale 1ns / 1ps
// one row of the score grid: holds its a base and last column score and move
// depends on oas_pkg

module oas_cell import oas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  oas_scores_t scores,
  input  oas_load_t   ld,
  input  oas_token_t  tin,
  output oas_token_t  tout
);

  logic                      active;
  logic [BASE_W-1:0]         a_base;
  logic signed [SCORE_W-1:0] score;
  oas_move_t                 move;

  logic signed [SCORE_W-1:0] old_s;
  oas_move_t                 old_m;
  logic signed [SUM_W-1:0]   diag_c;
  logic signed [SUM_W-1:0]   up_c;
  logic signed [SUM_W-1:0]   left_c;
  logic signed [SUM_W-1:0]   best;
  logic signed [SCORE_W-1:0] best_sat;
  oas_move_t                 best_mv;
  logic                      have;
  oas_token_t                tnext;

  always_comb begin
    old_s  = tin.first ? '0 : score;
    old_m  = tin.first ? MV_UP : move;
    diag_c = SUM_W'(tin.diag_src)
             + SUM_W'(bases_match(a_base, tin.b) ? scores.match : scores.mismatch);
    up_c   = SUM_W'(tin.up_src)
             + SUM_W'((tin.up_mv == MV_UP) ? scores.gap_cont : scores.gap_start);
    left_c = SUM_W'(old_s)
             + SUM_W'((old_m == MV_LEFT) ? scores.gap_cont : scores.gap_start);

    // ties keep diagonal, then up, then left
    best    = diag_c;
    best_mv = MV_DIAG;
    have    = tin.diag_ok;
    if (tin.up_ok && (!have || up_c > best)) begin
      best    = up_c;
      best_mv = MV_UP;
      have    = 1'b1;
    end
    if (!have || left_c > best) begin
      best    = left_c;
      best_mv = MV_LEFT;
    end

    if (best[SUM_W-1] != best[SUM_W-2]) begin
      best_sat = best[SUM_W-1] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      best_sat = best[SCORE_W-1:0];
    end

    tnext = tin;
    if (active) begin
      tnext.diag_ok  = 1'b1;
      tnext.diag_src = old_s;
      tnext.up_ok    = 1'b1;
      tnext.up_src   = best_sat;
      tnext.up_mv    = best_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ld.wr) begin
      active <= 1'b1;
    end else if (ld.clear) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.wr) a_base <= ld.base;
    if (en && tin.vld && active) begin
      score <= best_sat;
      move  <= best_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.vld <= 1'b0;
    end else if (en) begin
      tout <= tnext;
    end
  end

endmodule

// ===== sv/overlap_alignment_score_fill.sv =====
`timescale 1ns / 1ps
// overlap alignment score fill: a row of MAX_A_LEN cells, one per base of a
// depends on oas_pkg, oas_item_if, oas_result_if, oas_cfg_if, oas_cell
//
// usage
//   item channel: op 0 appends base to sequence a (restart empties a first),
//   op 1 fills one column of the grid for base of b (restart makes it column 1).
//   op 0 words give no result; each op 1 word gives one result word.
//   result channel: column index, last-row score and move, and a valid flag
//   that is low while a is empty.
//   cfg channel: four signed 7-bit penalties, always ready; write them only
//   while no column word is in flight.
// timing
//   a column word walks down the cell row, one cell per cycle unless the row
//   is frozen, through all cells and the output register, whatever the length of a.
//   column words enter back to back, one per cycle unless frozen; an op 0 word
//   waits until the cell row has drained.
// reset
//   sequence a empty, column count zero, penalties at 5, -4, -12, -4.
// stall
//   while a result waits in the output register the whole row freezes and
//   no column word is taken; loading a is not affected.

module overlap_alignment_score_fill import oas_pkg::*; #(
  parameter int MAX_A_LEN = 1024,
  parameter int MAX_B_LEN = 4096
) (
  input logic          clk,
  input logic          rst,
  oas_item_if.sink     item,
  oas_result_if.source result,
  oas_cfg_if.sink      cfg
);

  localparam int LW = $clog2(MAX_A_LEN + 1);
  localparam int CW = $clog2(MAX_B_LEN + 1);
  localparam int IW = $clog2(MAX_A_LEN + 1);

  oas_scores_t scores;
  logic [LW-1:0] a_length;
  logic [CW-1:0] column_count;
  logic [IW-1:0] in_flight;

  // chain advance: output register empty or being taken
  logic en;
  logic take;
  logic inject;
  logic load;
  logic exit_tok;

  // a load decode
  logic [LW-1:0] row;
  logic          row_wr;

  // column bookkeeping
  logic [CW-1:0]    col_base;
  logic [CW-1:0]    column_count_next;
  logic [COL_W-1:0] col_out;

  oas_token_t tok [MAX_A_LEN+1];

  assign en       = !result.valid || result.ready;
  assign item.ready = item.op ? en : (in_flight == '0);
  assign take     = item.valid && item.ready;
  assign inject   = take && item.op;
  assign load     = take && !item.op;
  assign exit_tok = en && tok[MAX_A_LEN].vld;
  assign cfg.ready = 1'b1;

  // a full drops further appends
  assign row    = item.restart ? '0 : a_length;
  assign row_wr = load && (item.restart || (a_length < LW'(MAX_A_LEN)));

  assign col_base = item.restart ? '0 : column_count;
  assign column_count_next = (col_base < CW'(MAX_B_LEN)) ? col_base + 1'b1 : col_base;

  generate
    if (CW >= COL_W) begin : g_col_trunc
      assign col_out = column_count_next[COL_W-1:0];
    end else begin : g_col_ext
      assign col_out = {{(COL_W-CW){1'b0}}, column_count_next};
    end
  endgenerate

  // penalty registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scores.match     <= MATCH_RST;
      scores.mismatch  <= MISMATCH_RST;
      scores.gap_start <= GAP_OPEN_RST;
      scores.gap_cont  <= GAP_EXTEND_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_MATCH:      scores.match     <= cfg.data;
        CFG_MISMATCH:   scores.mismatch  <= cfg.data;
        CFG_GAP_OPEN:   scores.gap_start <= cfg.data;
        CFG_GAP_EXTEND: scores.gap_cont  <= cfg.data;
      endcase
    end
  end

  // sequence a length and column count
  always_ff @(posedge clk) begin
    if (rst) begin
      a_length     <= '0;
      column_count <= '0;
    end else if (load) begin
      if (row_wr) a_length <= row + 1'b1;
      else if (item.restart) a_length <= '0;
      column_count <= '0;
    end else if (inject) begin
      column_count <= column_count_next;
    end
  end

  // words inside the cell row, used to hold a loads off
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      unique case ({inject, exit_tok})
        2'b10:   in_flight <= in_flight + 1'b1;
        2'b01:   in_flight <= in_flight - 1'b1;
        default: in_flight <= in_flight;
      endcase
    end
  end

  // column word into row 0: row 0 has no up neighbor, diagonal only at column 1
  always_comb begin
    tok[0].vld      = inject;
    tok[0].b        = item.base;
    tok[0].first    = (col_base == '0);
    tok[0].diag_ok  = (col_base == '0);
    tok[0].diag_src = '0;
    tok[0].up_ok    = 1'b0;
    tok[0].up_src   = '0;
    tok[0].up_mv    = MV_UP;
    tok[0].col      = col_out;
  end

  // inactive cells past the end of a pass the word through unchanged
  generate
    for (genvar i = 0; i < MAX_A_LEN; i++) begin : g_cell
      oas_load_t ld;
      always_comb begin
        ld.wr    = row_wr && (row == LW'(i));
        ld.clear = load && item.restart;
        ld.base  = item.base;
      end

      oas_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .en     (en),
        .scores (scores),
        .ld     (ld),
        .tin    (tok[i]),
        .tout   (tok[i+1])
      );
    end
  endgenerate

  // output register; up_ok set means some row of a was filled
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= tok[MAX_A_LEN].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_tok) begin
      result.column_index   <= tok[MAX_A_LEN].col;
      result.last_row_valid <= tok[MAX_A_LEN].up_ok;
      if (tok[MAX_A_LEN].up_ok) begin
        result.last_row_score <= tok[MAX_A_LEN].up_src;
        result.last_row_move  <= tok[MAX_A_LEN].up_mv;
      end else begin
        result.last_row_score <= '0;
        result.last_row_move  <= MV_DIAG;
      end
    end
  end

endmodule

// ===== verif/overlap_alignment_score_fill_tb.sv =====
`timescale 1ns / 1ps
// testbench for overlap_alignment_score_fill: directed and random a loads and b columns,
// every result word checked against a score grid predictor kept in a small class
// depends on oas_pkg, oas_item_if, oas_result_if, oas_cfg_if and the block

package oas_tb_pkg;
  import oas_pkg::*;

  localparam int     A_DEPTH  = 1024;
  localparam int     B_DEPTH  = 4096;
  localparam longint SCORE_HI = (longint'(1) <<< (SCORE_W - 1)) - 1;
  localparam longint SCORE_LO = -(longint'(1) <<< (SCORE_W - 1));

  typedef enum bit {
    OP_LOAD   = 1'b0,
    OP_COLUMN = 1'b1
  } item_op_t;

  typedef struct packed {
    logic [COL_W-1:0]          col;
    logic signed [SCORE_W-1:0] score;
    logic [1:0]                mv;
    logic                      vld;
  } column_word_t;

  function automatic logic [BASE_W-1:0] fold_case(logic [BASE_W-1:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  // nucleotide set of an ambiguity letter, zero for anything else
  function automatic logic [3:0] ambiguity_code(logic [BASE_W-1:0] c);
    case (c | 8'h20)
      "a":     return 4'b0001;
      "c":     return 4'b0010;
      "g":     return 4'b0100;
      "t":     return 4'b1000;
      "r":     return 4'b0101;
      "y":     return 4'b1010;
      "s":     return 4'b0110;
      "w":     return 4'b1001;
      "k":     return 4'b1100;
      "m":     return 4'b0011;
      "b":     return 4'b1110;
      "d":     return 4'b1101;
      "h":     return 4'b1011;
      "v":     return 4'b0111;
      "n":     return 4'b1111;
      default: return 4'b0000;
    endcase
  endfunction

  function automatic bit bases_agree(logic [BASE_W-1:0] a, logic [BASE_W-1:0] b);
    logic [3:0] ca;
    logic [3:0] cb;
    logic [3:0] ov;
    ca = ambiguity_code(a);
    cb = ambiguity_code(b);
    ov = ca & cb;
    if (fold_case(a) == fold_case(b)) return 1'b1;
    // only n carries the full set
    if (ca == 4'b1111 || cb == 4'b1111) return 1'b1;
    return (ca != 4'b0000) && (cb != 4'b0000) && ((ov == ca) || (ov == cb));
  endfunction

  class score_grid_board;
    logic [BASE_W-1:0] seq_a [A_DEPTH];
    int unsigned       a_len;
    int                col_score [A_DEPTH];
    oas_move_t         col_move [A_DEPTH];
    int unsigned       col_cnt;
    int                pen_match;
    int                pen_mismatch;
    int                pen_open;
    int                pen_extend;
    column_word_t      awaited [$];
    int unsigned       faults;

    function new();
      a_len        = 0;
      col_cnt      = 0;
      faults       = 0;
      pen_match    = MATCH_RST;
      pen_mismatch = MISMATCH_RST;
      pen_open     = GAP_OPEN_RST;
      pen_extend   = GAP_EXTEND_RST;
      foreach (col_score[i]) begin
        col_score[i] = 0;
        col_move[i]  = MV_UP;
      end
    endfunction

    function void set_reg(oas_cfg_idx_t idx, logic [PEN_W-1:0] v);
      case (idx)
        CFG_MATCH:      pen_match    = int'($signed(v));
        CFG_MISMATCH:   pen_mismatch = int'($signed(v));
        CFG_GAP_OPEN:   pen_open     = int'($signed(v));
        CFG_GAP_EXTEND: pen_extend   = int'($signed(v));
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_item(item_op_t op, logic [BASE_W-1:0] b, bit rs);
      if (op == OP_LOAD) begin
        if (rs) a_len = 0;
        if (a_len < A_DEPTH) begin
          seq_a[a_len] = b;
          a_len++;
        end
        col_cnt = 0;
        return;
      end
      if (rs) col_cnt = 0;
      fill_column(b);
    endfunction

    // walk one column down rows 1..a_len, keep it as the previous column
    function void fill_column(logic [BASE_W-1:0] b);
      longint       diag_src;
      longint       up_src;
      longint       best;
      longint       cand;
      longint       old_s;
      bit           diag_ok;
      bit           up_ok;
      bit           first;
      bit           have;
      oas_move_t    up_mv;
      oas_move_t    best_mv;
      oas_move_t    old_m;
      column_word_t w;
      int           i;
      diag_src = 0;
      up_src   = 0;
      best     = 0;
      up_ok    = 1'b0;
      up_mv    = MV_UP;
      best_mv  = MV_DIAG;
      first    = (col_cnt == 0);
      diag_ok  = first;
      for (i = 0; i < a_len; i++) begin
        old_s = first ? 0 : col_score[i];
        if (first) old_m = MV_UP;
        else old_m = col_move[i];
        have  = 1'b0;
        if (diag_ok) begin
          best    = diag_src + (bases_agree(seq_a[i], b) ? pen_match : pen_mismatch);
          best_mv = MV_DIAG;
          have    = 1'b1;
        end
        if (up_ok) begin
          cand = up_src + ((up_mv == MV_UP) ? pen_extend : pen_open);
          if (!have || cand > best) begin
            best    = cand;
            best_mv = MV_UP;
            have    = 1'b1;
          end
        end
        cand = old_s + ((old_m == MV_LEFT) ? pen_extend : pen_open);
        if (!have || cand > best) begin
          best    = cand;
          best_mv = MV_LEFT;
        end
        if (best > SCORE_HI) best = SCORE_HI;
        if (best < SCORE_LO) best = SCORE_LO;
        col_score[i] = int'(best);
        col_move[i]  = best_mv;
        diag_ok      = 1'b1;
        diag_src     = old_s;
        up_ok        = 1'b1;
        up_src       = best;
        up_mv        = best_mv;
      end
      if (col_cnt < B_DEPTH) col_cnt++;
      w.col = col_cnt[COL_W-1:0];
      if (a_len == 0) begin
        w.score = '0;
        w.mv    = MV_DIAG;
        w.vld   = 1'b0;
      end else begin
        w.score = best[SCORE_W-1:0];
        w.mv    = best_mv;
        w.vld   = 1'b1;
      end
      awaited = {awaited, w};
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      faults++;
    endfunction

    function void check_word(column_word_t got);
      column_word_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word, column %0d score %0d", $time,
                 got.col, $signed(got.score));
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got.col !== want.col) report("column_index", want.col, got.col);
      if (got.score !== want.score)
        report("last_row_score", longint'($signed(want.score)), longint'($signed(got.score)));
      if (got.mv !== want.mv) report("last_row_move", want.mv, got.mv);
      if (got.vld !== want.vld) report("last_row_valid", want.vld, got.vld);
    endfunction
  endclass

endpackage

module overlap_alignment_score_fill_tb;
  import oas_pkg::*;
  import oas_tb_pkg::*;

  // watchdog time limit for the whole run, in ns
  localparam int LIMIT_NS = 1_600_000 * 12;
  // extra wait after the drain, covering a pass down the cell row
  localparam int DRAIN_CYCLES = A_DEPTH + 16;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 56;

  logic clk = 1'b0;
  logic rst;
  int   tx_idle_pct = 7;
  int   rx_idle_pct = 56;

  score_grid_board board;

  oas_item_if   item_bus ();
  oas_result_if result_bus ();
  oas_cfg_if    cfg_bus ();

  overlap_alignment_score_fill #(
    .MAX_A_LEN(A_DEPTH),
    .MAX_B_LEN(B_DEPTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #6 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    result_bus.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    column_word_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.col   = result_bus.column_index;
      got.score = result_bus.last_row_score;
      got.mv    = result_bus.last_row_move;
      got.vld   = result_bus.last_row_valid;
      board.check_word(got);
    end
  end

  // one word on the item channel; valid stays high after acceptance so the
  // next word can follow back to back
  task automatic send_word(item_op_t op, logic [BASE_W-1:0] b, bit rs);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.op      <= op;
    item_bus.base    <= b;
    item_bus.restart <= rs;
    do @(posedge clk); while (!item_bus.ready);
    board.note_item(op, b, rs);
  endtask

  // sender holds off until every outstanding column has come back
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // drained plus a full pass of the cell row, so a trailing load is done too
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(oas_cfg_idx_t idx, logic [PEN_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, v);
  endtask

  // only called with the block idle
  task automatic write_regs(logic [PEN_W-1:0] m, logic [PEN_W-1:0] mm,
                            logic [PEN_W-1:0] go, logic [PEN_W-1:0] ge);
    put_reg(CFG_MATCH, m);
    put_reg(CFG_MISMATCH, mm);
    put_reg(CFG_GAP_OPEN, go);
    put_reg(CFG_GAP_EXTEND, ge);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [PEN_W-1:0] rand_pen();
    int v;
    v = int'($urandom_range(126)) - 63;
    return v[PEN_W-1:0];
  endfunction

  // mostly plain nucleotides, some ambiguity codes, some arbitrary bytes
  function automatic logic [BASE_W-1:0] pick_base();
    string             nuc;
    string             amb;
    int                r;
    logic [BASE_W-1:0] raw;
    nuc = "ACGTacgt";
    amb = "RYSWKMBDHVNryswkmbdhvn";
    r   = $urandom_range(99);
    raw = BASE_W'($urandom_range(255));
    if (r < 65) return nuc[$urandom_range(nuc.len() - 1)];
    if (r < 85) return amb[$urandom_range(amb.len() - 1)];
    return raw;
  endfunction

  function automatic int pick_a_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 10);
    if (r < 97) return $urandom_range(11, 48);
    return $urandom_range(49, 200);
  endfunction

  task automatic directed_checks();
    // empty a: result flagged invalid, columns still counted
    send_word(OP_COLUMN, "A", 1'b1);
    send_word(OP_COLUMN, "C", 1'b0);
    // a with case, n, ambiguity code and non-nucleotide bytes
    send_word(OP_LOAD, "A", 1'b1);
    send_word(OP_LOAD, "c", 1'b0);
    send_word(OP_LOAD, "N", 1'b0);
    send_word(OP_LOAD, "R", 1'b0);
    send_word(OP_LOAD, 8'h00, 1'b0);
    send_word(OP_LOAD, 8'hFF, 1'b0);
    send_word(OP_LOAD, "X", 1'b0);
    // lower case, n wildcard, disjoint and subset codes, raw bytes
    send_word(OP_COLUMN, "a", 1'b1);
    send_word(OP_COLUMN, "n", 1'b0);
    send_word(OP_COLUMN, "G", 1'b0);
    send_word(OP_COLUMN, "Y", 1'b0);
    send_word(OP_COLUMN, 8'hFF, 1'b0);
    send_word(OP_COLUMN, 8'h00, 1'b0);
    send_word(OP_COLUMN, "r", 1'b0);
    send_word(OP_COLUMN, "x", 1'b0);
    // an append in the middle of b starts the columns over
    send_word(OP_LOAD, "T", 1'b0);
    send_word(OP_COLUMN, "T", 1'b0);
    wait_drained();
    send_word(OP_COLUMN, "b", 1'b0);
    // all-zero penalties: all scores stay zero, so the candidates of each cell tie
    settle();
    write_regs('0, '0, '0, '0);
    send_word(OP_COLUMN, "A", 1'b1);
    send_word(OP_COLUMN, "C", 1'b0);
    send_word(OP_COLUMN, "A", 1'b0);
  endtask

  // groups of a load (in most groups) then a run of b columns; stray appends break some runs
  task automatic random_traffic(int budget);
    int sent;
    int n;
    int k;
    bit rs;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 70) begin
        n = pick_a_len();
        for (k = 0; k < n; k++) begin
          send_word(OP_LOAD, pick_base(), k == 0);
          sent++;
        end
      end
      n = $urandom_range(1, 24);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(199) == 0) wait_drained();
        if ($urandom_range(99) < 3) begin
          send_word(OP_LOAD, pick_base(), $urandom_range(3) == 0);
          sent++;
        end
        rs = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        send_word(OP_COLUMN, pick_base(), rs);
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    int k;
    board = new();
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.op        <= OP_LOAD;
    item_bus.base      <= '0;
    item_bus.restart   <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_MATCH;
    cfg_bus.data       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_checks();

    for (p = 0; p < PHASES; p++) begin
      // sender light / receiver heavy, then swapped, then free running
      if (p < PHASES / 3) begin
        tx_idle_pct = 7;
        rx_idle_pct = 56;
      end else if (p < 2 * PHASES / 3) begin
        tx_idle_pct = 56;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      settle();
      case (p)
        0:       write_regs(7'sd63, -7'sd63, -7'sd63, -7'sd63);
        1:       write_regs(-7'sd63, 7'sd63, 7'sd63, 7'sd63);
        2:       write_regs(MATCH_RST, MISMATCH_RST, GAP_OPEN_RST, GAP_EXTEND_RST);
        4:       write_regs(7'sd63, 7'sd63, 7'sd63, 7'sd63);
        5:       write_regs(-7'sd1, -7'sd1, -7'sd1, -7'sd1);
        8:       write_regs(-7'sd63, -7'sd63, -7'sd63, -7'sd63);
        9:       write_regs(7'sd1, -7'sd1, -7'sd2, 7'sd0);
        default: write_regs(rand_pen(), rand_pen(), rand_pen(), rand_pen());
      endcase
      random_traffic(PHASE_ITEMS);
    end

    // a full: appends past the top are dropped
    settle();
    write_regs(rand_pen(), rand_pen(), rand_pen(), rand_pen());
    for (k = 0; k < A_DEPTH + 6; k++) send_word(OP_LOAD, pick_base(), k == 0);
    for (k = 0; k < 12; k++) send_word(OP_COLUMN, pick_base(), k == 0);

    settle();
    if (board.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== overlap_alignment_score_fill.f =====
sv/oas_pkg.sv
sv/oas_item_if.sv
sv/oas_result_if.sv
sv/oas_cfg_if.sv
sv/oas_cell.sv
sv/overlap_alignment_score_fill.sv
verif/overlap_alignment_score_fill_tb.sv
